// ===== src/oes_pkg.sv =====
package oes_pkg;

  // default parameter values for the top level
  localparam int DEF_SAMPLE_WIDTH = 24;
  localparam int DEF_FRAC_BITS    = 12;

  // fixed field widths
  localparam int RATE_W  = 16;
  localparam int CUT_W   = 24;
  localparam int GAIN_W  = 32;
  localparam int DERIV_W = 32;

  // shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // omega = fc * 2pi, fc in Q16.16, 2pi in Q28
  localparam logic [MUL_W-1:0] TWOPI_Q28 = 32'd1686629713;
  localparam int TWOPI_SHIFT = 28;
  localparam int OMEGA_W     = 35;
  localparam int RATE_SHIFT  = 16;
  localparam int DEN_W       = OMEGA_W + 1;

  // alpha in Q1.24, never above one
  localparam int ALPHA_FRAC = 24;
  localparam int ALPHA_W    = ALPHA_FRAC + 1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;
  localparam int DIVIDEND_W = OMEGA_W + ALPHA_FRAC + 1;
  localparam int LO_W       = ALPHA_FRAC + ALPHA_W;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_RATE   = 2'd0;
  localparam logic [1:0] REG_MINCUT = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;
  localparam logic [1:0] REG_DCUT   = 2'd3;

  localparam logic [RATE_W-1:0] RST_RATE   = 16'd25;
  localparam logic [CUT_W-1:0]  RST_MINCUT = 24'd3277;
  localparam logic [GAIN_W-1:0] RST_GAIN   = 32'd83886;
  localparam logic [CUT_W-1:0]  RST_DCUT   = 24'd65536;

  typedef struct packed {
    logic busy;
    logic done;
  } oes_div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DER_DIFF,
    ST_DER_MUL,
    ST_DER_SAT,
    ST_OMG_MUL,
    ST_OMG_DEN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SM_DIFF,
    ST_SM_MLO,
    ST_SM_MHI,
    ST_SM_ADD,
    ST_SM_APPLY,
    ST_GAIN_MUL,
    ST_GAIN_ADD,
    ST_FINISH
  } oes_state_t;

endpackage

// ===== src/oes_mul.sv =====
module oes_mul
  import oes_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] product
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  assign product = prod_r;

endmodule

// ===== src/oes_div.sv =====
module oes_div
  import oes_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DEN_W-1:0]      divisor,
  output oes_div_stat_t         stat,
  output logic [ALPHA_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(ALPHA_W + 1);

  logic [DEN_W-1:0]   rem_r;
  logic [DEN_W-1:0]   den_r;
  logic [ALPHA_W-1:0] low_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     trial_sub;
  logic               ge;

  // restoring step: one quotient bit per cycle, quotient shifts into low_r
  assign trial     = {rem_r, low_r[ALPHA_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign ge        = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ALPHA_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(dividend[DIVIDEND_W-1:ALPHA_W]);
      low_r <= dividend[ALPHA_W-1:0];
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[ALPHA_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = low_r;

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  a_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> low_r <= ALPHA_ONE)
    else $error("alpha above one");
`endif

endmodule

// ===== src/one_euro_adaptive_smoother_core.sv =====
// channel   direction  signals                          transfer when
// input     in         in_valid, in_ready, in_sample    in_valid && in_ready
// result    out        out_valid, out_ready, out_smoothed  out_valid && out_ready
// config    in         psel, penable, pwrite, paddr,    psel && penable && pwrite
//                      pwdata, prdata, pready
//
// first sample after reset: passed straight through, from IDLE to FINISH without filtering
// later samples: a derivative pass and a value pass, each with a 25-step serial alpha division
// one shared 32x32 multiplier and one restoring divider under a single sequencer
// rst_n is synchronous: clears filter state and restores register defaults
// a result waiting in the output register blocks only the final step
module one_euro_adaptive_smoother_core
  import oes_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_smoothed,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ADDR_W-1:0]              paddr,
  input  logic [DATA_W-1:0]              pwdata,
  output logic [DATA_W-1:0]              prdata,
  output logic                           pready
);

  localparam int MAG_W = (SAMPLE_WIDTH > DERIV_W) ? SAMPLE_WIDTH + 1 : DERIV_W + 1;
  localparam int GAIN_SHIFT = 8 + FRAC_BITS;

  oes_state_t state_r, state_nxt;

  logic [RATE_W-1:0] rate_r;
  logic [CUT_W-1:0]  min_cut_r;
  logic [GAIN_W-1:0] gain_r;
  logic [CUT_W-1:0]  dcut_r;

  logic                    first_r;
  logic                    pass_r;
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] prev_out_r;
  logic [DERIV_W-1:0]      prev_deriv_r;

  logic [SAMPLE_WIDTH-1:0] x_r;
  logic [SAMPLE_WIDTH-1:0] res_r;
  logic [SAMPLE_WIDTH-1:0] out_data_r;
  logic [DERIV_W-1:0]      dx_r;
  logic [MAG_W-1:0]        mag_r;
  logic                    neg_r;
  logic [MAG_W-1:0]        base_r;
  logic [MAG_W-1:0]        scaled_r;
  logic [ALPHA_W-1:0]      lo_part_r;
  logic [ALPHA_W-1:0]      alpha_r;
  logic [GAIN_W-1:0]       fc_r;
  logic [OMEGA_W-1:0]      w_r;
  logic [DEN_W-1:0]        den_r;

  logic [RATE_W-1:0]     rate_eff;
  logic                  mul_en;
  logic [MUL_W-1:0]      mul_a;
  logic [MUL_W-1:0]      mul_b;
  logic [PROD_W-1:0]     mul_prod;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  oes_div_stat_t         div_stat;
  logic [ALPHA_W-1:0]    div_q;

  logic                  cfg_wr;
  logic                  finish_go;
  logic [MAG_W-1:0]      sub_tgt;
  logic [MAG_W-1:0]      sub_base;
  logic [MAG_W-1:0]      sub_d;
  logic [MAG_W-1:0]      sub_mag;
  logic [47:0]           prod48;
  logic                  dx_big;
  logic [DERIV_W-1:0]    dx_sat;
  logic [DERIV_W-1:0]    abs_pd;
  logic [PROD_W:0]       fc_sum;
  logic [GAIN_W-1:0]     fc_sat;
  logic [OMEGA_W-1:0]    w_nxt;
  logic [DEN_W-1:0]      den_nxt;
  logic [LO_W-1:0]       lo_sum;
  logic [MAG_W-1:0]      sm_res;

  oes_mul u_mul (
    .clk     (clk),
    .en      (mul_en),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .product (mul_prod)
  );

  oes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (den_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // a zero rate acts as one
  assign rate_eff = (rate_r == '0) ? RATE_W'(1) : rate_r;
  assign cfg_wr   = psel && penable && pwrite;

  // shared subtractor: derivative pass smooths dx against prev_deriv, otherwise x against prev_out
  always_comb begin
    if (state_r == ST_SM_DIFF && !pass_r) begin
      sub_tgt  = {{(MAG_W-DERIV_W){dx_r[DERIV_W-1]}}, dx_r};
      sub_base = {{(MAG_W-DERIV_W){prev_deriv_r[DERIV_W-1]}}, prev_deriv_r};
    end else begin
      sub_tgt  = {{(MAG_W-SAMPLE_WIDTH){x_r[SAMPLE_WIDTH-1]}}, x_r};
      sub_base = {{(MAG_W-SAMPLE_WIDTH){prev_out_r[SAMPLE_WIDTH-1]}}, prev_out_r};
    end
  end

  assign sub_d   = sub_tgt - sub_base;
  assign sub_mag = sub_d[MAG_W-1] ? (MAG_W'(0) - sub_d) : sub_d;

  // derivative saturation to signed 32 bits
  assign prod48 = mul_prod[47:0];
  assign dx_big = |mag_r[MAG_W-1:DERIV_W];
  always_comb begin
    if (neg_r) begin
      dx_sat = (dx_big || prod48 > 48'h0000_8000_0000) ? 32'h8000_0000
                                                        : (32'd0 - prod48[31:0]);
    end else begin
      dx_sat = (dx_big || prod48 > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                        : prod48[31:0];
    end
  end

  // adaptive cutoff
  assign abs_pd = prev_deriv_r[DERIV_W-1] ? (DERIV_W'(0) - prev_deriv_r) : prev_deriv_r;
  assign fc_sum = (PROD_W+1)'(min_cut_r) + (PROD_W+1)'(mul_prod >> GAIN_SHIFT);
  assign fc_sat = (|fc_sum[PROD_W:GAIN_W]) ? '1 : fc_sum[GAIN_W-1:0];

  // omega and alpha denominator
  assign w_nxt   = mul_prod[OMEGA_W+TWOPI_SHIFT-1:TWOPI_SHIFT];
  assign den_nxt = DEN_W'(w_nxt) + (DEN_W'(rate_eff) << RATE_SHIFT);
  assign div_dividend = DIVIDEND_W'({w_r, {ALPHA_FRAC{1'b0}}})
                      + DIVIDEND_W'(den_r[DEN_W-1:1]);

  // low half of mag * alpha, rounded half up
  assign lo_sum = mul_prod[LO_W-1:0] + (LO_W'(1) << (ALPHA_FRAC - 1));
  assign sm_res = neg_r ? (base_r - scaled_r) : (base_r + scaled_r);

  assign finish_go = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = first_r ? ST_FINISH : ST_DER_DIFF;
      ST_DER_DIFF: state_nxt = ST_DER_MUL;
      ST_DER_MUL:  state_nxt = ST_DER_SAT;
      ST_DER_SAT:  state_nxt = ST_OMG_MUL;
      ST_OMG_MUL:  state_nxt = ST_OMG_DEN;
      ST_OMG_DEN:  state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_stat.done) state_nxt = ST_SM_DIFF;
      ST_SM_DIFF:  state_nxt = ST_SM_MLO;
      ST_SM_MLO:   state_nxt = ST_SM_MHI;
      ST_SM_MHI:   state_nxt = ST_SM_ADD;
      ST_SM_ADD:   state_nxt = ST_SM_APPLY;
      ST_SM_APPLY: state_nxt = pass_r ? ST_FINISH : ST_GAIN_MUL;
      ST_GAIN_MUL: state_nxt = ST_GAIN_ADD;
      ST_GAIN_ADD: state_nxt = ST_OMG_MUL;
      ST_FINISH:   if (finish_go) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_DER_MUL: begin
        mul_en = 1'b1;
        mul_a  = mag_r[MUL_W-1:0];
        mul_b  = MUL_W'(rate_eff);
      end
      ST_OMG_MUL: begin
        mul_en = 1'b1;
        mul_a  = fc_r;
        mul_b  = TWOPI_Q28;
      end
      ST_DIV_GO: div_start = 1'b1;
      ST_SM_MLO: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(mag_r[ALPHA_FRAC-1:0]);
        mul_b  = MUL_W'(alpha_r);
      end
      ST_SM_MHI: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(mag_r[MAG_W-1:ALPHA_FRAC]);
        mul_b  = MUL_W'(alpha_r);
      end
      ST_GAIN_MUL: begin
        mul_en = 1'b1;
        mul_a  = gain_r;
        mul_b  = abs_pd;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rate_r       <= RST_RATE;
      min_cut_r    <= RST_MINCUT;
      gain_r       <= RST_GAIN;
      dcut_r       <= RST_DCUT;
      first_r      <= 1'b1;
      pass_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_out_r   <= '0;
      prev_deriv_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_RATE:   rate_r    <= pwdata[RATE_W-1:0];
          REG_MINCUT: min_cut_r <= pwdata[CUT_W-1:0];
          REG_GAIN:   gain_r    <= pwdata[GAIN_W-1:0];
          REG_DCUT:   dcut_r    <= pwdata[CUT_W-1:0];
          default:    rate_r    <= rate_r;
        endcase
      end
      if (state_r == ST_IDLE && in_valid) begin
        first_r <= 1'b0;
      end
      if (state_r == ST_DER_SAT) begin
        pass_r <= 1'b0;
      end
      if (state_r == ST_GAIN_ADD) begin
        pass_r <= 1'b1;
      end
      if (state_r == ST_SM_APPLY && !pass_r) begin
        prev_deriv_r <= sm_res[DERIV_W-1:0];
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (finish_go) begin
        out_valid_r <= 1'b1;
        prev_out_r  <= res_r;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        x_r   <= in_sample;
        res_r <= in_sample;
      end
      ST_DER_DIFF, ST_SM_DIFF: begin
        mag_r  <= sub_mag;
        neg_r  <= sub_d[MAG_W-1];
        base_r <= sub_base;
      end
      ST_DER_SAT: begin
        dx_r <= dx_sat;
        fc_r <= GAIN_W'(dcut_r);
      end
      ST_OMG_DEN: begin
        w_r   <= w_nxt;
        den_r <= den_nxt;
      end
      ST_DIV_WAIT: if (div_stat.done) alpha_r <= div_q;
      ST_SM_MHI:   lo_part_r <= lo_sum[LO_W-1:ALPHA_FRAC];
      ST_SM_ADD:   scaled_r <= mul_prod[MAG_W-1:0] + MAG_W'(lo_part_r);
      ST_SM_APPLY: if (pass_r) res_r <= sm_res[SAMPLE_WIDTH-1:0];
      ST_GAIN_ADD: fc_r <= fc_sat;
      default:     x_r <= x_r;
    endcase
    if (finish_go) begin
      out_data_r <= res_r;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RATE:   prdata = DATA_W'(rate_r);
      REG_MINCUT: prdata = DATA_W'(min_cut_r);
      REG_GAIN:   prdata = DATA_W'(gain_r);
      REG_DCUT:   prdata = DATA_W'(dcut_r);
      default:    prdata = '0;
    endcase
  end

  assign pready       = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_smoothed = out_data_r;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_first_clears_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(first_r) |-> $past(in_valid && in_ready))
    else $error("first-sample flag cleared without an input transfer");

  a_step_within_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SM_APPLY) |-> scaled_r <= mag_r)
    else $error("filter step overshoots its target");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside the finish step");
`endif

endmodule
